@@ hw/rtl/reorder_buffer_in_order_retire_core_macros.svh @@
// ----------------------------------------------------------------------------
// Reorder buffer assertion macros
// Assertion macros shared by the reorder buffer RTL.
// ----------------------------------------------------------------------------
`ifndef REORDER_BUFFER_IN_ORDER_RETIRE_CORE_MACROS_SVH
`define REORDER_BUFFER_IN_ORDER_RETIRE_CORE_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ROB_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ROB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared types, request and response codes and default sizes.
// ----------------------------------------------------------------------------
package rob_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int RETIRE_MAX    = 32;

   // Request codes on the input channel.
   localparam logic [2:0] REQ_ALLOC   = 3'd0;
   localparam logic [2:0] REQ_EXEC    = 3'd1;
   localparam logic [2:0] REQ_FINISH  = 3'd2;
   localparam logic [2:0] REQ_SETRES  = 3'd3;
   localparam logic [2:0] REQ_RETIRE  = 3'd4;
   localparam logic [2:0] REQ_FLUSH   = 3'd5;

   // Internal operation codes after classification.
   localparam logic [2:0] OP_NOP      = 3'd0;
   localparam logic [2:0] OP_ALLOC    = 3'd1;
   localparam logic [2:0] OP_EXEC     = 3'd2;
   localparam logic [2:0] OP_FINISH   = 3'd3;
   localparam logic [2:0] OP_SETRES   = 3'd4;
   localparam logic [2:0] OP_RETIRE   = 3'd5;
   localparam logic [2:0] OP_FLUSH    = 3'd6;

   // Entry kinds.
   localparam logic [2:0] KIND_REG     = 3'd0;
   localparam logic [2:0] KIND_JUMP    = 3'd2;
   localparam logic [2:0] KIND_SYSCALL = 3'd3;

   // Entry status.
   localparam logic [1:0] STAT_EMPTY  = 2'd0;
   localparam logic [1:0] STAT_ISSUED = 2'd1;
   localparam logic [1:0] STAT_EXEC   = 2'd2;
   localparam logic [1:0] STAT_DONE   = 2'd3;

   // Response kinds.
   localparam logic [2:0] RSP_ACK       = 3'd0;
   localparam logic [2:0] RSP_ALLOC     = 3'd1;
   localparam logic [2:0] RSP_REG_WRITE = 3'd2;
   localparam logic [2:0] RSP_REDIRECT  = 3'd3;
   localparam logic [2:0] RSP_HALT      = 3'd4;
   localparam logic [2:0] RSP_NO_ACTION = 3'd5;
   localparam logic [2:0] RSP_REFUSED   = 3'd6;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [2:0]         entry_kind;
      logic [31:0]        dest_value;
      logic [4:0]         entry_index;
      logic signed [31:0] result_value;
   } rob_req_type;

   typedef struct packed {
      logic [2:0]         resp_kind;
      logic [4:0]         alloc_index;
      logic [31:0]        out_dest;
      logic signed [31:0] out_value;
      logic               flush_request;
      logic [31:0]        retired_total;
      logic               last;
   } rob_rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic [2:0]  op;
      logic        index_ok;
      logic [2:0]  kind;
      logic [31:0] dest;
      logic [4:0]  index;
      logic [31:0] result;
   } rob_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rob_qstat_type;

endpackage

@@ hw/rtl/rob_front.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer front end
// Accepts requests, range-checks the entry index and classifies the request.
// ----------------------------------------------------------------------------
module rob_front #(
   parameter int DEPTH = rob_pkg::DEPTH_DEFAULT
) (
   input  logic                  start,
   input  rob_pkg::rob_req_type  req_data,
   input  rob_pkg::rob_qstat_type q_stat,
   output logic                  busy,
   output logic                  push,
   output rob_pkg::rob_cmd_type  push_cmd
);

   assign busy = q_stat.full;
   assign push = start && !q_stat.full;

   always_comb begin
      push_cmd.kind     = req_data.entry_kind;
      push_cmd.dest     = req_data.dest_value;
      push_cmd.index    = req_data.entry_index;
      push_cmd.result   = req_data.result_value;
      push_cmd.index_ok = 32'(req_data.entry_index) < 32'(DEPTH);
      case (req_data.req_type)
         rob_pkg::REQ_ALLOC:  push_cmd.op = rob_pkg::OP_ALLOC;
         rob_pkg::REQ_EXEC:   push_cmd.op = rob_pkg::OP_EXEC;
         rob_pkg::REQ_FINISH: push_cmd.op = rob_pkg::OP_FINISH;
         rob_pkg::REQ_SETRES: push_cmd.op = rob_pkg::OP_SETRES;
         rob_pkg::REQ_RETIRE: push_cmd.op = rob_pkg::OP_RETIRE;
         rob_pkg::REQ_FLUSH:  push_cmd.op = rob_pkg::OP_FLUSH;
         default:             push_cmd.op = rob_pkg::OP_NOP;
      endcase
   end

endmodule

@@ hw/rtl/rob_queue.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer command queue
// Two-entry queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
`include "reorder_buffer_in_order_retire_core_macros.svh"

module rob_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rob_pkg::rob_cmd_type   push_cmd,
   input  logic                   pop,
   output rob_pkg::rob_cmd_type   pop_cmd,
   output rob_pkg::rob_qstat_type q_stat
);

   logic [1:0]           count_ff, count_in;
   rob_pkg::rob_cmd_type slot0_ff, slot0_in;
   rob_pkg::rob_cmd_type slot1_ff, slot1_in;
   logic                 do_pop;

   assign do_pop       = pop && (count_ff != 2'd0);
   assign pop_cmd      = slot0_ff;
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (do_pop) begin
         slot0_in = slot1_ff;
      end
      // The write lands in the first free slot after any pop has shifted.
      if (push) begin
         if ((count_ff == 2'd0) || ((count_ff == 2'd1) && do_pop)) begin
            slot0_in = push_cmd;
         end else begin
            slot1_in = push_cmd;
         end
      end
      count_in = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `ROB_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff != 2'd3, "queue count overflow")
   `ROB_ASSERT_NEXT(a_push_counts, clock, reset, push && !pop && (count_ff == 2'd0), count_ff == 2'd1, "push into empty queue lost")

endmodule

@@ hw/rtl/rob_back.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer back end
// Holds the entries and pointers, executes commands and walks retirement.
// ----------------------------------------------------------------------------
`include "reorder_buffer_in_order_retire_core_macros.svh"

module rob_back #(
   parameter int DEPTH = rob_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rob_pkg::rob_cmd_type   cmd,
   input  rob_pkg::rob_qstat_type q_stat,
   output logic                   pop,
   output logic                   rsp_strobe,
   output rob_pkg::rob_rsp_type   rsp_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LIMIT  = (DEPTH < rob_pkg::RETIRE_MAX) ? DEPTH : rob_pkg::RETIRE_MAX;
   localparam int STEP_W = $clog2(LIMIT + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [31:0]       count_ff, count_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [1:0]        status_ff [DEPTH];
   logic [1:0]        status_in [DEPTH];

   logic                 rsp_valid_ff, rsp_valid_in;
   rob_pkg::rob_rsp_type rsp_ff, rsp_in;

   // Entry payload memories, read at the tail with registered data.
   logic [2:0]  kind_mem [DEPTH];
   logic [31:0] dest_mem [DEPTH];
   logic [31:0] res_mem  [DEPTH];
   logic [2:0]  rd_kind_ff;
   logic [31:0] rd_dest_ff;
   logic [31:0] rd_res_ff;
   logic        rd_en;

   logic             meta_we;
   logic             res_we;
   logic [IDX_W-1:0] res_addr;
   logic [31:0]      res_wdata;
   logic [IDX_W-1:0] ix;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] tail_next;
   logic             tail_done;

   assign ix        = IDX_W'(cmd.index);
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_done = (status_ff[tail_ff] == rob_pkg::STAT_DONE) &&
                      (steps_ff < STEP_W'(LIMIT));

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pop          = 1'b0;
      rd_en        = 1'b0;
      meta_we      = 1'b0;
      res_we       = 1'b0;
      res_addr     = ix;
      res_wdata    = cmd.result;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop                  = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.resp_kind     = rob_pkg::RSP_ACK;
               rsp_in.last          = 1'b1;
               rsp_in.retired_total = count_ff;
               case (cmd.op)
                  rob_pkg::OP_ALLOC: begin
                     if (occ_ff >= CNT_W'(DEPTH)) begin
                        rsp_in.resp_kind = rob_pkg::RSP_REFUSED;
                     end else begin
                        meta_we            = 1'b1;
                        res_we             = 1'b1;
                        res_addr           = head_ff;
                        res_wdata          = '0;
                        status_in[head_ff] = rob_pkg::STAT_ISSUED;
                        rsp_in.resp_kind   = rob_pkg::RSP_ALLOC;
                        rsp_in.alloc_index = 5'(head_ff);
                        head_in            = head_next;
                        occ_in             = occ_ff + 1'b1;
                     end
                  end
                  rob_pkg::OP_EXEC: begin
                     if (cmd.index_ok && (status_ff[ix] != rob_pkg::STAT_EMPTY)) begin
                        status_in[ix] = rob_pkg::STAT_EXEC;
                     end
                  end
                  rob_pkg::OP_FINISH: begin
                     if (cmd.index_ok && (status_ff[ix] != rob_pkg::STAT_EMPTY)) begin
                        status_in[ix] = rob_pkg::STAT_DONE;
                        res_we        = 1'b1;
                     end
                  end
                  rob_pkg::OP_SETRES: begin
                     res_we = cmd.index_ok;
                  end
                  rob_pkg::OP_RETIRE: begin
                     // The walk answers on its own; nothing goes out now.
                     rsp_valid_in = 1'b0;
                     steps_in     = '0;
                     state_in     = ST_LOOK;
                  end
                  rob_pkg::OP_FLUSH: begin
                     for (int i = 0; i < DEPTH; i++) begin
                        status_in[i] = rob_pkg::STAT_EMPTY;
                     end
                     head_in = '0;
                     tail_in = '0;
                     occ_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (tail_done) begin
               rd_en    = 1'b1;
               state_in = ST_EMIT;
            end else begin
               rsp_valid_in         = 1'b1;
               rsp_in.resp_kind     = rob_pkg::RSP_ACK;
               rsp_in.retired_total = count_ff;
               rsp_in.last          = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_EMIT: begin
            status_in[tail_ff] = rob_pkg::STAT_EMPTY;
            tail_in            = tail_next;
            count_in           = count_ff + 1'b1;
            steps_in           = steps_ff + 1'b1;
            if (occ_ff != '0) begin
               occ_in = occ_ff - 1'b1;
            end
            rsp_valid_in         = 1'b1;
            rsp_in.retired_total = count_ff + 1'b1;
            rsp_in.resp_kind     = rob_pkg::RSP_NO_ACTION;
            if (rd_kind_ff == rob_pkg::KIND_REG) begin
               rsp_in.resp_kind = rob_pkg::RSP_REG_WRITE;
               rsp_in.out_dest  = rd_dest_ff;
               rsp_in.out_value = rd_res_ff;
            end else if ((rd_kind_ff == rob_pkg::KIND_JUMP) && (rd_res_ff != '0)) begin
               rsp_in.resp_kind     = rob_pkg::RSP_REDIRECT;
               rsp_in.out_dest      = rd_dest_ff;
               rsp_in.flush_request = 1'b1;
            end else if (rd_kind_ff == rob_pkg::KIND_SYSCALL) begin
               rsp_in.resp_kind = rob_pkg::RSP_HALT;
            end
            state_in = ST_LOOK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            status_ff[i] <= rob_pkg::STAT_EMPTY;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         kind_mem[head_ff] <= cmd.kind;
         dest_mem[head_ff] <= cmd.dest;
      end
      if (rd_en) begin
         rd_kind_ff <= kind_mem[tail_ff];
         rd_dest_ff <= dest_mem[tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_addr] <= res_wdata;
      end
      if (rd_en) begin
         rd_res_ff <= res_mem[tail_ff];
      end
   end

   `ROB_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CNT_W'(DEPTH), "occupancy above depth")
   `ROB_ASSERT_ALWAYS(a_pop_idle, clock, reset, !pop || (state_ff == ST_IDLE), "command taken during retire walk")
   `ROB_ASSERT_NEXT(a_emit_rsp, clock, reset, state_ff == ST_EMIT, rsp_valid_ff && !rsp_ff.last, "retired entry without response")

endmodule

@@ hw/rtl/reorder_buffer_in_order_retire_core.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer with in-order retirement
// Circular buffer of instruction entries, allocated at the head and retired
// in order from the tail.
// ----------------------------------------------------------------------------
// Usage:
//   A request is transferred on a rising edge with start high and busy low.
//   Requests go into a two-entry queue; busy is high while that queue is full.
//   Every request produces results on rsp_data, each shown for exactly one
//   cycle with rsp_strobe high; the final result of a request has last set.
//   The receiver cannot stall, so results are never held back.
//   With the queue empty, a request is registered in the queue, taken by the
//   back end, and its first result is registered onto rsp_data. Allocate, mark
//   executing, finish, set result and flush are each done as the back end
//   takes the command from the queue. A retire walks from the tail: the back
//   end takes the request, then for each retired entry reads the tail payload
//   from the entry memories and then retires it, and it closes with an
//   acknowledge once the tail entry is not done or the walk limit is reached.
//   Synchronous reset empties all entries, clears the pointers, the
//   occupancy and the retired count, and drains the queue.
// ----------------------------------------------------------------------------
module reorder_buffer_in_order_retire_core #(
   parameter int DEPTH = rob_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rob_pkg::rob_req_type req_data,
   output logic                 rsp_strobe,
   output rob_pkg::rob_rsp_type rsp_data
);

   logic                   push;
   logic                   pop;
   rob_pkg::rob_cmd_type   push_cmd;
   rob_pkg::rob_cmd_type   pop_cmd;
   rob_pkg::rob_qstat_type q_stat;

   rob_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .start    (start),
      .req_data (req_data),
      .q_stat   (q_stat),
      .busy     (busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rob_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   rob_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pop_cmd),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
